@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the centroid table block.
// Depends on a clk and an active-low arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define LCC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that implies a consequence on the next edge.
`define LCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/lcc_pkg.sv @@
// Package for the leader clustering centroid table: widths, register indexes,
// controller state type. No dependencies.
package lcc_pkg;

	localparam int NUM_CLASSES_DEF = 6;
	localparam int CLUSTERS_DEF    = 8;

	localparam int COORD_W = 16;
	localparam int MEAN_W  = 24;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 7;
	localparam int COLOR_W = 3;
	localparam int NUM_W   = 41;  // mean*count + point*256, signed
	localparam int DEN_W   = 17;  // count+1
	localparam int SQ_W    = 50;
	localparam int LIM_W   = 38;
	localparam int RAD_W   = 19;
	localparam int ENTRY_W = 3 * MEAN_W + CNT_W;
	localparam int REC_W   = COLOR_W + 3 * COORD_W + CNT_W;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 72;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [RAD_W-1:0] MM_PER_CM_Q8 = 19'd2560;
	localparam logic [RAD_W-1:0] RAD_RESET = 19'd25600;
	localparam logic [CFG_W-1:0] MIN_RESET = 7'd20;

	localparam logic CFG_DIST_LIMIT = 1'b0;
	localparam logic CFG_MIN_SIZE   = 1'b1;
	localparam logic FUNC_EOF       = 1'b1;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_LOOK  = 12'b000000000010,
		S_RD    = 12'b000000000100,
		S_SQ    = 12'b000000001000,
		S_CMP   = 12'b000000010000,
		S_DIV   = 12'b000000100000,
		S_WB    = 12'b000001000000,
		E_NEXT  = 12'b000010000000,
		E_RD    = 12'b000100000000,
		E_CHK   = 12'b001000000000,
		E_FLUSH = 12'b010000000000,
		S_DROP  = 12'b100000000000
	} state_t;

endpackage

@@ hw/rtl/leader_cluster_centroid_table.sv @@
// Top level of the leader clustering centroid table.
// Depends on lcc_pkg and assert_macros.svh.
// One item is worked at a time. An add-point transaction runs a lookup step, then for each
// cluster tried a memory read, a squares step and a compare step; on a match it runs the
// three bit-serial dividers (one per axis) and a write-back, unless the cluster count is
// full. A point of an unknown color is dropped as it is accepted. An end-of-frame
// transaction takes one step per color, a read and a check step per stored cluster and
// three more for accept, end check and flush, and waits whenever the output register is
// not taken. The cluster memory needs no clearing pass: per-color fill levels mark which
// entries are live.

`include "assert_macros.svh"

module leader_cluster_centroid_table #(
	parameter int NUM_CLASSES        = lcc_pkg::NUM_CLASSES_DEF,
	parameter int CLUSTERS_PER_CLASS = lcc_pkg::CLUSTERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// color_class[2:0], point_x[18:3], point_y[34:19], point_z[50:35], zero pad
	input  logic [lcc_pkg::IN_TDATA_W-1:0]   s_tdata,
	// func
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// cluster_color[2:0], centre_x[18:3], centre_y[34:19], centre_z[50:35],
	// cluster_size[66:51], zero pad
	output logic [lcc_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// entry_valid
	output logic                             m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [lcc_pkg::CFG_W-1:0]        cfg_data
);

	localparam int DEPTH = NUM_CLASSES * CLUSTERS_PER_CLASS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(NUM_CLASSES + 1);
	localparam int IW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int KW    = (CLUSTERS_PER_CLASS > 1) ? $clog2(CLUSTERS_PER_CLASS) : 1;
	localparam int FW    = $clog2(CLUSTERS_PER_CLASS + 1);
	localparam int DCW   = $clog2(lcc_pkg::NUM_W + 1);
	localparam int MW    = lcc_pkg::MEAN_W;
	localparam int NW    = lcc_pkg::NUM_W;

	lcc_pkg::state_t state_q;

	logic [lcc_pkg::RAD_W-1:0]   rad_q;
	logic [lcc_pkg::CFG_W-1:0]   min_q;
	logic [lcc_pkg::LIM_W-1:0]   lim_q;
	logic [FW-1:0]               fill_q [NUM_CLASSES];
	logic [CW-1:0]               c_q;
	logic [KW-1:0]               k_q;
	logic [FW-1:0]               n_q;
	logic                        open_q;
	logic signed [lcc_pkg::COORD_W-1:0] p_q [3];
	logic [lcc_pkg::SQ_W-1:0]    sq_q [3];
	logic signed [NW-1:0]        prod_q [3];
	logic [NW-1:0]               mag_q [3];
	logic [lcc_pkg::DEN_W-1:0]   rem_q [3];
	logic                        neg_q [3];
	logic [DCW-1:0]              div_cnt_q;
	logic [lcc_pkg::REC_W-1:0]   pend_q;
	logic                        pend_v_q;
	logic [lcc_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                        out_user_q;
	logic                        out_last_q;
	logic                        out_v_q;

	// cluster memory: {count, mean_z, mean_y, mean_x}
	logic [lcc_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic [lcc_pkg::ENTRY_W-1:0] rdata;
	logic [lcc_pkg::ENTRY_W-1:0] wdata;
	logic [AW-1:0]               addr;
	logic                        mem_we;

	logic signed [MW-1:0]        mean [3];
	logic [lcc_pkg::CNT_W-1:0]   cnt;
	logic [lcc_pkg::DEN_W-1:0]   den;
	logic [lcc_pkg::SQ_W+1:0]    dist_sq;
	logic                        hit;
	logic signed [NW-1:0]        num [3];
	logic [lcc_pkg::REC_W-1:0]   rec;
	logic                        out_free;
	logic [lcc_pkg::DEN_W:0]     trial [3];
	logic [MW-1:0]               quo [3];
	logic [FW-1:0]               fill_c;
	logic                        chk_keep;
	logic                        chk_go;
	logic                        out_load;

	assign addr = AW'(32'(c_q) * CLUSTERS_PER_CLASS + 32'(k_q));
	assign mem_we = (state_q == lcc_pkg::S_WB);
	assign fill_c = fill_q[c_q[IW-1:0]];

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

	always_comb begin
		cnt = rdata[3*MW +: lcc_pkg::CNT_W];
		den = {1'b0, cnt} + 1'b1;
		for (int i = 0; i < 3; i++) begin
			mean[i] = rdata[i*MW +: MW];
			num[i] = prod_q[i] + NW'($signed({p_q[i], 8'h00}));
			trial[i] = {rem_q[i], mag_q[i][NW-1]} - {1'b0, den};
			quo[i] = neg_q[i] ? MW'(-mag_q[i]) : mag_q[i][MW-1:0];
		end
		dist_sq = (lcc_pkg::SQ_W+2)'(sq_q[0]) + (lcc_pkg::SQ_W+2)'(sq_q[1])
			+ (lcc_pkg::SQ_W+2)'(sq_q[2]);
		hit = dist_sq < (lcc_pkg::SQ_W+2)'(lim_q);
		rec = {cnt, mean[2][MW-1:8], mean[1][MW-1:8], mean[0][MW-1:8],
			lcc_pkg::COLOR_W'(c_q)};
		if (open_q)
			wdata = {lcc_pkg::CNT_W'(1), p_q[2], 8'h00, p_q[1], 8'h00, p_q[0], 8'h00};
		else
			wdata = {cnt + 1'b1, quo[2], quo[1], quo[0]};
	end

	// end-of-frame check: keep the cluster, and whether the pending slot can move on
	assign chk_keep = cnt >= lcc_pkg::CNT_W'(min_q);
	assign chk_go   = !chk_keep || !pend_v_q || out_free;
	assign out_load = ((state_q == lcc_pkg::E_CHK) && chk_keep && chk_go && pend_v_q)
		|| ((state_q == lcc_pkg::E_FLUSH) && out_free);

	assign out_free  = !out_v_q || m_tready;
	assign s_tready  = (state_q == lcc_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;
	assign m_tlast   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q <= lcc_pkg::RAD_RESET;
			min_q <= lcc_pkg::MIN_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == lcc_pkg::CFG_DIST_LIMIT)
				rad_q <= lcc_pkg::RAD_W'(cfg_data * lcc_pkg::MM_PER_CM_Q8);
			else
				min_q <= cfg_data;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			lcc_pkg::S_IDLE: begin
				p_q[0] <= s_tdata[18:3];
				p_q[1] <= s_tdata[34:19];
				p_q[2] <= s_tdata[50:35];
			end
			lcc_pkg::S_LOOK: begin
				lim_q <= rad_q * rad_q;
			end
			lcc_pkg::S_SQ: begin
				for (int i = 0; i < 3; i++) begin
					logic signed [MW:0] d;
					d = {p_q[i][15], p_q[i], 8'h00} - {mean[i][MW-1], mean[i]};
					sq_q[i] <= lcc_pkg::SQ_W'(d * d);
					prod_q[i] <= NW'(mean[i] * $signed({1'b0, cnt}));
				end
			end
			lcc_pkg::S_CMP: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= num[i][NW-1];
					mag_q[i] <= num[i][NW-1] ? -num[i] : num[i];
					rem_q[i] <= '0;
				end
			end
			lcc_pkg::S_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if (!trial[i][lcc_pkg::DEN_W]) begin
						rem_q[i] <= trial[i][lcc_pkg::DEN_W-1:0];
						mag_q[i] <= {mag_q[i][NW-2:0], 1'b1};
					end else begin
						rem_q[i] <= {rem_q[i][lcc_pkg::DEN_W-2:0], mag_q[i][NW-1]};
						mag_q[i] <= {mag_q[i][NW-2:0], 1'b0};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lcc_pkg::S_IDLE;
			c_q        <= '0;
			k_q        <= '0;
			n_q        <= '0;
			open_q     <= 1'b0;
			div_cnt_q  <= '0;
			pend_q     <= '0;
			pend_v_q   <= 1'b0;
			out_data_q <= '0;
			out_user_q <= 1'b0;
			out_last_q <= 1'b0;
			out_v_q    <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++)
				fill_q[i] <= '0;
		end else begin
			if (out_v_q && m_tready && !out_load)
				out_v_q <= 1'b0;
			unique case (state_q)
				lcc_pkg::S_IDLE: begin
					if (s_tvalid) begin
						c_q <= '0;
						if (s_tuser == lcc_pkg::FUNC_EOF)
							state_q <= lcc_pkg::E_NEXT;
						else if (32'(s_tdata[2:0]) < NUM_CLASSES) begin
							c_q <= CW'(s_tdata[2:0]);
							state_q <= lcc_pkg::S_LOOK;
						end
					end
				end
				lcc_pkg::S_LOOK: begin
					n_q <= fill_c;
					if (fill_c == '0) begin
						k_q <= '0;
						open_q <= 1'b1;
						state_q <= lcc_pkg::S_WB;
					end else begin
						k_q <= KW'(fill_c - 1'b1);
						open_q <= 1'b0;
						state_q <= lcc_pkg::S_RD;
					end
				end
				lcc_pkg::S_RD: state_q <= lcc_pkg::S_SQ;
				lcc_pkg::S_SQ: state_q <= lcc_pkg::S_CMP;
				lcc_pkg::S_CMP: begin
					div_cnt_q <= '0;
					if (hit)
						state_q <= (cnt == lcc_pkg::COUNT_MAX) ? lcc_pkg::S_DROP
							: lcc_pkg::S_DIV;
					else if (k_q != '0) begin
						k_q <= k_q - 1'b1;
						state_q <= lcc_pkg::S_RD;
					end else if (32'(n_q) < CLUSTERS_PER_CLASS) begin
						k_q <= KW'(n_q);
						open_q <= 1'b1;
						state_q <= lcc_pkg::S_WB;
					end else
						state_q <= lcc_pkg::S_DROP;
				end
				lcc_pkg::S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCW'(NW - 1))
						state_q <= lcc_pkg::S_WB;
				end
				lcc_pkg::S_WB: begin
					if (open_q)
						fill_q[c_q[IW-1:0]] <= n_q + 1'b1;
					state_q <= lcc_pkg::S_IDLE;
				end
				lcc_pkg::S_DROP: state_q <= lcc_pkg::S_IDLE;
				lcc_pkg::E_NEXT: begin
					if (c_q == CW'(NUM_CLASSES))
						state_q <= lcc_pkg::E_FLUSH;
					else begin
						fill_q[c_q[IW-1:0]] <= '0;
						if (fill_c == '0)
							c_q <= c_q + 1'b1;
						else begin
							k_q <= KW'(fill_c - 1'b1);
							state_q <= lcc_pkg::E_RD;
						end
					end
				end
				lcc_pkg::E_RD: state_q <= lcc_pkg::E_CHK;
				lcc_pkg::E_CHK: begin
					if (chk_keep && chk_go) begin
						if (pend_v_q) begin
							out_data_q <= lcc_pkg::OUT_TDATA_W'(pend_q);
							out_user_q <= 1'b1;
							out_last_q <= 1'b0;
							out_v_q <= 1'b1;
						end
						pend_q <= rec;
						pend_v_q <= 1'b1;
					end
					if (chk_go) begin
						if (k_q == '0) begin
							c_q <= c_q + 1'b1;
							state_q <= lcc_pkg::E_NEXT;
						end else begin
							k_q <= k_q - 1'b1;
							state_q <= lcc_pkg::E_RD;
						end
					end
				end
				lcc_pkg::E_FLUSH: begin
					if (out_free) begin
						out_data_q <= pend_v_q ? lcc_pkg::OUT_TDATA_W'(pend_q) : '0;
						out_user_q <= pend_v_q;
						out_last_q <= 1'b1;
						out_v_q <= 1'b1;
						pend_v_q <= 1'b0;
						state_q <= lcc_pkg::S_IDLE;
					end
				end
				default: state_q <= lcc_pkg::S_IDLE;
			endcase
		end
	end

	`LCC_ASSERT(a_state_onehot, $onehot(state_q), "controller state not one-hot")
	`LCC_ASSERT(a_marker_zero, !(m_tvalid && m_tlast && !m_tuser) || (m_tdata == '0), "empty-frame marker carries data")
	`LCC_ASSERT(a_wr_in_range, !mem_we || (32'(addr) < DEPTH), "cluster write outside table")
	`LCC_ASSERT(a_idle_no_pend, !s_tready || !pend_v_q, "pending result left behind at idle")
	`LCC_ASSERT_NEXT(a_div_ends, (state_q == lcc_pkg::S_DIV) && (div_cnt_q == DCW'(NW - 1)), state_q == lcc_pkg::S_WB, "divider did not hand over to write-back")

endmodule
